// File: hdl/kwlc_pkg.sv
// ----------------------------------------------------------------------------
// kwlc_pkg: shared types and constants of the keyword/line/char counter
// Field widths, register indexes, special bytes and the keyword byte select.
// ----------------------------------------------------------------------------
package kwlc_pkg;

  localparam int unsigned MAX_KEY_CHARS_DEF = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned KEY_LEN_W = 5;
  localparam int unsigned KEY_IDX_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] TERM_BYTE    = 8'h00;
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } kwlc_cfg_e;

  // per-transfer event from the front end to the tally
  typedef struct packed {
    logic take;     // byte transferred
    logic term;     // byte is the terminator
    logic newline;  // byte is a newline
    logic hit;      // keyword ends at this byte
  } kwlc_ev_t;

  // keyword character idx: 0..7 from the low word, 8..15 from the high word
  function automatic logic [BYTE_W-1:0] key_char(input logic [KEY_W-1:0] lo,
                                                 input logic [KEY_W-1:0] hi,
                                                 input logic [KEY_IDX_W-1:0] idx);
    logic [KEY_W-1:0] word;
    word = idx[KEY_IDX_W-1] ? hi : lo;
    return word[idx[KEY_IDX_W-2:0]*BYTE_W +: BYTE_W];
  endfunction

endpackage

// File: hdl/kwlc_cell.sv
// ----------------------------------------------------------------------------
// kwlc_cell: one window position
// Holds one recent byte and its valid flag, shifts it on to the next cell and
// compares the byte entering it against the keyword character for its place.
// ----------------------------------------------------------------------------
module kwlc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic                          clear_i,
  input  logic [kwlc_pkg::BYTE_W-1:0]   byte_i,
  input  logic                          valid_i,
  input  logic [kwlc_pkg::BYTE_W-1:0]   key_i,
  input  logic                          in_use_i,
  output logic [kwlc_pkg::BYTE_W-1:0]   byte_o,
  output logic                          valid_o,
  output logic                          eq_o
);

  logic [kwlc_pkg::BYTE_W-1:0] byte_q;
  logic                        valid_q, valid_d;

  // compare on the incoming byte: that is this position after the shift
  assign eq_o = !in_use_i || (valid_i && (byte_i == key_i));

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// File: hdl/kwlc_tally.sv
// ----------------------------------------------------------------------------
// kwlc_tally: saturating counters and result register
// Counts characters, newlines and keyword hits of the current text and loads
// the result register when the terminator is transferred.
// ----------------------------------------------------------------------------
module kwlc_tally (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kwlc_pkg::kwlc_ev_t           ev_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [kwlc_pkg::CNT_W-1:0]   line_total_o,
  output logic [kwlc_pkg::CNT_W-1:0]   char_total_o,
  output logic [kwlc_pkg::CNT_W-1:0]   match_total_o
);

  logic [kwlc_pkg::CNT_W-1:0] len_q, len_d, nl_q, nl_d, hit_q, hit_d;
  logic [kwlc_pkg::CNT_W-1:0] len_inc, nl_inc, hit_inc;
  logic [kwlc_pkg::CNT_W-1:0] line_q, char_q, match_q;
  logic                       out_valid_q, out_valid_d;
  logic                       load;

  assign load = ev_i.take && ev_i.term;

  assign len_inc = (len_q == kwlc_pkg::CNT_MAX) ? len_q : len_q + 1'b1;
  assign nl_inc  = (nl_q  == kwlc_pkg::CNT_MAX) ? nl_q  : nl_q  + 1'b1;
  assign hit_inc = (hit_q == kwlc_pkg::CNT_MAX) ? hit_q : hit_q + 1'b1;

  always_comb begin
    len_d = len_q;
    nl_d  = nl_q;
    hit_d = hit_q;
    if (load) begin
      len_d = '0;
      nl_d  = '0;
      hit_d = '0;
    end else if (ev_i.take) begin
      len_d = len_inc;
      if (ev_i.newline) nl_d = nl_inc;
      if (ev_i.hit) hit_d = hit_inc;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      nl_q        <= '0;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      nl_q        <= nl_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // an empty text reports zero lines
  always_ff @(posedge clk_i) begin
    if (load) begin
      line_q  <= (len_q == '0) ? '0 : nl_inc;
      char_q  <= len_q;
      match_q <= hit_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_total_o  = line_q;
  assign char_total_o  = char_q;
  assign match_total_o = match_q;

endmodule

// File: hdl/keyword_line_char_counter.sv
// ----------------------------------------------------------------------------
// keyword_line_char_counter: keyword, line and character counter
// Takes one text byte per transfer; a zero byte ends the text and yields one
// result with line, character and overlapping keyword counts.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; the keyword compare across the cell row and
// the counter increments finish in the cycle of the transfer.
// Latency: the result is valid the cycle after the terminator transfer.
// Input stalls only while a result is held by a stalled output.
// Reset: asynchronous, clears keyword registers, window flags, counters and
// the result valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyword_line_char_counter #(
  parameter int unsigned MAX_KEY_CHARS = kwlc_pkg::MAX_KEY_CHARS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kwlc_pkg::BYTE_W-1:0]      text_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [kwlc_pkg::CNT_W-1:0]       line_total_o,
  output logic [kwlc_pkg::CNT_W-1:0]       char_total_o,
  output logic [kwlc_pkg::CNT_W-1:0]       match_total_o,
  input  logic                             cfg_we_i,
  input  logic [kwlc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kwlc_pkg::KEY_W-1:0]       cfg_data_i
);

  logic [kwlc_pkg::KEY_W-1:0]     key_lo_q, key_hi_q;
  logic [kwlc_pkg::KEY_LEN_W-1:0] key_len_q, eff_len;

  logic [kwlc_pkg::BYTE_W-1:0] win_byte  [MAX_KEY_CHARS+1];
  logic                        win_valid [MAX_KEY_CHARS+1];
  logic [MAX_KEY_CHARS-1:0]    cell_eq;
  logic [MAX_KEY_CHARS-1:0]    cell_valid;

  logic               take, term, match;
  kwlc_pkg::kwlc_ev_t ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kwlc_pkg::CFG_KEY_LOW:  key_lo_q  <= cfg_data_i;
        kwlc_pkg::CFG_KEY_HIGH: key_hi_q  <= cfg_data_i;
        kwlc_pkg::CFG_KEY_LEN:  key_len_q <= cfg_data_i[kwlc_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (key_len_q > kwlc_pkg::KEY_LEN_W'(MAX_KEY_CHARS))
                 ? kwlc_pkg::KEY_LEN_W'(MAX_KEY_CHARS) : key_len_q;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign term       = (text_byte_i == kwlc_pkg::TERM_BYTE);

  // the incoming byte enters cell 0; cell j sees the byte j places back
  assign win_byte[0]  = text_byte_i;
  assign win_valid[0] = 1'b1;

  for (genvar j = 0; j < MAX_KEY_CHARS; j++) begin : g_cell
    logic [kwlc_pkg::KEY_LEN_W-1:0] kidx;
    logic                           in_use;

    // newest byte lines up with the last keyword character
    assign kidx   = eff_len - kwlc_pkg::KEY_LEN_W'(j) - kwlc_pkg::KEY_LEN_W'(1);
    assign in_use = kwlc_pkg::KEY_LEN_W'(j) < eff_len;

    kwlc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (take && !term),
      .clear_i  (take && term),
      .byte_i   (win_byte[j]),
      .valid_i  (win_valid[j]),
      .key_i    (kwlc_pkg::key_char(key_lo_q, key_hi_q,
                                    kidx[kwlc_pkg::KEY_IDX_W-1:0])),
      .in_use_i (in_use),
      .byte_o   (win_byte[j+1]),
      .valid_o  (win_valid[j+1]),
      .eq_o     (cell_eq[j])
    );

    assign cell_valid[j] = win_valid[j+1];
  end

  assign match = (eff_len != '0) && (&cell_eq);

  assign ev.take    = take;
  assign ev.term    = term;
  assign ev.newline = (text_byte_i == kwlc_pkg::NEWLINE_BYTE);
  assign ev.hit     = match;

  kwlc_tally u_tally (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_i          (ev),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .line_total_o  (line_total_o),
    .char_total_o  (char_total_o),
    .match_total_o (match_total_o)
  );

  a_term_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && term |=> out_valid_o)
    else $error("terminator transfer did not produce a result");

  a_term_clears_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && term |=> (cell_valid == '0))
    else $error("window not cleared after terminator");

  a_match_le_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (match_total_o <= char_total_o))
    else $error("more matches than characters");

  a_empty_text_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((line_total_o == '0) == (char_total_o == '0)))
    else $error("line count disagrees with empty text");

endmodule

// File: bench/kwlc_checker.sv
// ----------------------------------------------------------------------------
// kwlc_checker: result checker for the keyword/line/char counter
// Watches the text, result and register ports, keeps its own copy of the
// keyword registers and per-text counters, predicts one tally per terminator
// and compares each result transfer, field by field, with the oldest tally.
// ----------------------------------------------------------------------------
module kwlc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [kwlc_pkg::BYTE_W-1:0]    text_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [kwlc_pkg::CNT_W-1:0]     line_total_i,
  input  logic [kwlc_pkg::CNT_W-1:0]     char_total_i,
  input  logic [kwlc_pkg::CNT_W-1:0]     match_total_i,
  input  logic                           cfg_we_i,
  input  logic [kwlc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kwlc_pkg::KEY_W-1:0]     cfg_data_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);

  localparam int unsigned WINDOW = kwlc_pkg::MAX_KEY_CHARS_DEF;

  typedef struct packed {
    logic [kwlc_pkg::CNT_W-1:0] lines;
    logic [kwlc_pkg::CNT_W-1:0] chars;
    logic [kwlc_pkg::CNT_W-1:0] hits;
  } text_tally_t;

  logic [2*kwlc_pkg::KEY_W-1:0]   keyword;
  logic [kwlc_pkg::KEY_LEN_W-1:0] key_len;
  logic [kwlc_pkg::BYTE_W-1:0]    window [WINDOW];  // newest byte at index 0
  logic [kwlc_pkg::CNT_W-1:0]     newlines;
  logic [kwlc_pkg::CNT_W-1:0]     text_len;
  logic [kwlc_pkg::CNT_W-1:0]     hits;
  text_tally_t                    tally_q [$];

  function automatic logic [kwlc_pkg::CNT_W-1:0] bump(input logic [kwlc_pkg::CNT_W-1:0] v);
    return (v == kwlc_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // keyword char 0 lines up with the oldest byte of the span
  function automatic logic keyword_ends_here();
    int unsigned span;
    logic        hit;
    span = (key_len > WINDOW) ? WINDOW : key_len;
    hit  = (span != 0) && (text_len >= span);
    for (int unsigned i = 0; i < span; i++) begin
      if (keyword[i*kwlc_pkg::BYTE_W +: kwlc_pkg::BYTE_W] != window[span-1-i]) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic clear_text();
    for (int i = 0; i < WINDOW; i++) window[i] = '0;
    newlines = '0;
    text_len = '0;
    hits     = '0;
  endtask

  task automatic take_byte(input logic [kwlc_pkg::BYTE_W-1:0] b);
    text_tally_t t;
    if (b == kwlc_pkg::TERM_BYTE) begin
      t.lines = (text_len == 0) ? '0 : bump(newlines);
      t.chars = text_len;
      t.hits  = hits;
      tally_q.push_back(t);
      clear_text();
    end else begin
      for (int i = WINDOW - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      text_len  = bump(text_len);
      if (b == kwlc_pkg::NEWLINE_BYTE) newlines = bump(newlines);
      if (keyword_ends_here()) hits = bump(hits);
    end
  endtask

  task automatic check_field(input string name, input logic [kwlc_pkg::CNT_W-1:0] want,
                             input logic [kwlc_pkg::CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  task automatic check_result();
    text_tally_t t;
    if (tally_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got lines %0d chars %0d matches %0d",
               $time, line_total_i, char_total_i, match_total_i);
      mismatch_count_o++;
    end else begin
      t = tally_q.pop_front();
      check_field("line_total", t.lines, line_total_i);
      check_field("char_total", t.chars, char_total_i);
      check_field("match_total", t.hits, match_total_i);
    end
  endtask

  // result first: a terminator taken at this edge reports at a later one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword = '0;
      key_len = '0;
      clear_text();
      tally_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) take_byte(text_byte_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          kwlc_pkg::CFG_KEY_LOW:
            keyword[kwlc_pkg::KEY_W-1:0] = cfg_data_i;
          kwlc_pkg::CFG_KEY_HIGH:
            keyword[2*kwlc_pkg::KEY_W-1:kwlc_pkg::KEY_W] = cfg_data_i;
          kwlc_pkg::CFG_KEY_LEN:
            key_len = cfg_data_i[kwlc_pkg::KEY_LEN_W-1:0];
          default: ;
        endcase
      end
      pending_o = tally_q.size();
    end
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of keyword_line_char_counter
// Directed texts for the empty, overlapping, short, zero-byte and oversized keyword cases,
// then random keyword settings with texts built from keyword pieces, newlines
// and random bytes. Bursty sender, stalling receiver; kwlc_checker predicts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RANDOM_BYTES = 1250;
  localparam int unsigned IDLE_LIMIT   = 2000;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [kwlc_pkg::BYTE_W-1:0]    text_byte_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [kwlc_pkg::CNT_W-1:0]     line_total_o;
  logic [kwlc_pkg::CNT_W-1:0]     char_total_o;
  logic [kwlc_pkg::CNT_W-1:0]     match_total_o;
  logic                           cfg_we_i    = 1'b0;
  logic [kwlc_pkg::CFG_IDX_W-1:0] cfg_index_i = kwlc_pkg::CFG_KEY_LOW;
  logic [kwlc_pkg::KEY_W-1:0]     cfg_data_i  = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned burst_left  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_level = 0;
  int unsigned stall_age   = 0;
  bit          no_gaps     = 1'b0;

  keyword_line_char_counter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_total_o (line_total_o),
    .char_total_o (char_total_o),
    .match_total_o(match_total_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  kwlc_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_total_i    (line_total_o),
    .char_total_i    (char_total_o),
    .match_total_i   (match_total_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: stall density is redrawn when its random age runs out, level 0 = none
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      stall_level = $urandom_range(0, 3);
      stall_age   = $urandom_range(50, 300);
    end else begin
      stall_age--;
    end
    out_stall_i <= (stall_level != 0) && ($urandom_range(1, 4) <= stall_level);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [kwlc_pkg::BYTE_W-1:0] text_char(input bit small_set);
    if (!small_set) return kwlc_pkg::BYTE_W'($urandom_range(1, 255));
    case ($urandom_range(0, 2))
      0:       return "a";
      1:       return "b";
      default: return kwlc_pkg::NEWLINE_BYTE;
    endcase
  endfunction

  task automatic send_byte(input logic [kwlc_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(kwlc_pkg::TERM_BYTE);
  endtask

  // idle the sender until every tally has come back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_keyword(input logic [kwlc_pkg::KEY_W-1:0] lo,
                              input logic [kwlc_pkg::KEY_W-1:0] hi,
                              input logic [kwlc_pkg::KEY_LEN_W-1:0] len);
    logic [kwlc_pkg::KEY_W-1:0] len_word;
    len_word = {$urandom, $urandom};  // upper bits are don't-care
    len_word[kwlc_pkg::KEY_LEN_W-1:0] = len;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= kwlc_pkg::CFG_KEY_LOW;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= kwlc_pkg::CFG_KEY_HIGH;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_index_i <= kwlc_pkg::CFG_KEY_LEN;
    cfg_data_i  <= len_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one keyword setting, a few texts of keyword pieces and noise, then drain
  task automatic run_phase();
    logic [2*kwlc_pkg::KEY_W-1:0]   key_bits;
    logic [kwlc_pkg::KEY_LEN_W-1:0] len_field;
    logic [kwlc_pkg::BYTE_W-1:0]    c;
    logic [kwlc_pkg::BYTE_W-1:0]    text_q [$];
    int unsigned                    span;
    int unsigned                    pick;
    int unsigned                    cut;
    int unsigned                    text_size;
    bit                             small_set;
    pick = $urandom_range(0, 15);
    if (pick == 0)      len_field = '0;
    else if (pick == 1) len_field = kwlc_pkg::KEY_LEN_W'(kwlc_pkg::MAX_KEY_CHARS_DEF);
    else if (pick == 2) len_field = kwlc_pkg::KEY_LEN_W'($urandom_range(17, 31));
    else if (pick < 6)  len_field = kwlc_pkg::KEY_LEN_W'($urandom_range(5, 15));
    else                len_field = kwlc_pkg::KEY_LEN_W'($urandom_range(1, 4));
    span      = (len_field > kwlc_pkg::MAX_KEY_CHARS_DEF) ? kwlc_pkg::MAX_KEY_CHARS_DEF
                                                          : len_field;
    small_set = ($urandom_range(0, 3) != 0);
    no_gaps   = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < kwlc_pkg::MAX_KEY_CHARS_DEF; i++) begin
      if (i < span) begin
        c = text_char(small_set);
        // zero key char, never matches
        if ($urandom_range(0, 19) == 0) c = kwlc_pkg::TERM_BYTE;
      end else begin
        c = kwlc_pkg::BYTE_W'($urandom_range(0, 255));
      end
      key_bits[i*kwlc_pkg::BYTE_W +: kwlc_pkg::BYTE_W] = c;
    end
    load_keyword(key_bits[kwlc_pkg::KEY_W-1:0],
                 key_bits[2*kwlc_pkg::KEY_W-1:kwlc_pkg::KEY_W], len_field);
    repeat ($urandom_range(1, 8)) begin
      text_q.delete();
      text_size = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 20);
      while (text_q.size() < text_size) begin
        pick = $urandom_range(0, 5);
        if (pick < 2) begin
          // whole keyword or a broken prefix of it
          cut = (pick == 0) ? span : $urandom_range(0, span);
          for (int i = 0; i < cut; i++) begin
            c = key_bits[i*kwlc_pkg::BYTE_W +: kwlc_pkg::BYTE_W];
            text_q.push_back((c == kwlc_pkg::TERM_BYTE) ? text_char(small_set) : c);
          end
          if (cut == 0) text_q.push_back(text_char(small_set));
        end else if (pick == 2) begin
          text_q.push_back(kwlc_pkg::BYTE_W'($urandom_range(1, 255)));
        end else begin
          text_q.push_back(text_char(small_set));
        end
      end
      foreach (text_q[i]) send_byte(text_q[i]);
      send_byte(kwlc_pkg::TERM_BYTE);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty keyword; byte extremes; empty text
    load_keyword('0, '0, '0);
    send_text("\377\n\001");
    send_text("");
    drain();
    // overlapping matches
    load_keyword(64'h6161, '0, 5'd2);
    send_text("aaa");
    drain();
    // short text against a keyword that starts with a zero char
    load_keyword(64'h6100, '0, 5'd2);
    send_text("a");
    drain();
    // oversized key length acts as sixteen
    load_keyword({8{8'h62}}, {8{8'h62}}, 5'd31);
    send_text("bbbbbbbbbbbbbbbb");
    drain();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) run_phase();

    drain();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
